### design/sfbm_pkg.sv
// Shared constants and types for the sound file bank mapper.
// Holds the bus address map, command codes, register indexes and the result record.
// Depends on nothing; every design file refers to it by scoped names.
`timescale 1ns / 1ps

package sfbm_pkg;

  // Fixed field widths
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned DATA_W     = 8;
  localparam int unsigned ROM_ADDR_W = 20;

  // Program banking: eight banks of 4 KB each
  localparam int unsigned BANK_COUNT = 8;
  localparam int unsigned BANK_BYTES = 4096;
  localparam int unsigned BANK_IDX_W = $clog2(BANK_COUNT);
  localparam int unsigned BANK_OFF_W = $clog2(BANK_BYTES);
  localparam int unsigned PRG_OFF_W  = BANK_IDX_W + BANK_OFF_W;

  // Work RAM default size and the largest window it is folded into. The smallest RAM
  // is 1 KB, so the fold quotient never exceeds 7 and three quotient bits cover it.
  localparam int unsigned WORK_RAM_BYTES_DEF = 8192;
  localparam int unsigned RAM_WINDOW_W       = 13;
  localparam int unsigned RAM_FOLD_STEPS     = 3;

  // Depth of the result queue in front of the output port
  localparam int unsigned OUT_DEPTH   = 4;
  localparam int unsigned OUT_PTR_W   = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_COUNT_W = OUT_PTR_W + 1;

  // CPU bus address map
  localparam logic [ADDR_W-1:0] ADDR_RELOAD_LO = 16'h401B;
  localparam logic [ADDR_W-1:0] ADDR_RELOAD_HI = 16'h401C;
  localparam logic [ADDR_W-1:0] ADDR_STATUS    = 16'h401D;
  localparam logic [ADDR_W-1:0] ADDR_BANK_BASE = 16'h5FF8;
  localparam logic [ADDR_W-1:0] ADDR_RAM       = 16'h6000;
  localparam logic [ADDR_W-1:0] ADDR_PRG       = 16'h8000;
  localparam logic [ADDR_W-1:0] ADDR_VEC_LO    = 16'hFFFE;

  // Configuration port
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic REG_BANK_SWITCH = 1'b0;
  localparam logic REG_IRQ_EXT     = 1'b1;

  // Bus commands
  typedef enum logic [CMD_W-1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_t;

  // One result beat
  typedef struct packed {
    logic [DATA_W-1:0]     read_data;
    logic                  rom_fetch;
    logic [ROM_ADDR_W-1:0] rom_address;
    logic                  irq_pending;
  } result_t;

endpackage

### design/sound_file_bank_mapper_with_irq_timer_top.sv
// Bus mapper for a music-file player cartridge: bank registers, work RAM and IRQ timer.
// Uses sfbm_pkg for the address map, command codes and the result record.
`timescale 1ns / 1ps

// Usage
// The input channel (in_valid / in_ready) takes one CPU read, write or cycle tick per
// beat; the output channel (out_valid / out_ready) returns exactly one result beat for
// each input beat, in order. The configuration port (APB style, pready tied high)
// holds the bank switch enable at byte address 0 and the IRQ extension enable at 4;
// write it only while no beat is in flight.
// Path: a result is registered in the read stage, for the synchronous work RAM read,
// then in the result queue, from which it is offered.
// Throughput: one beat per cycle while in_ready is high. Mapper state is updated at the
// accepting edge, so a beat always sees the effect of the one before it; work RAM reads
// and writes share a single memory port, which runs at the same rate.
// Stalls: a four-entry result queue parts the two channels. in_ready falls only once
// the queue plus the beat in the RAM read stage would fill it, or while the clearing pass runs.
// Reset: rst is synchronous and active high. It clears the registers, then a clearing
// pass writes zero into every work RAM byte, one byte a cycle; in_ready stays low
// meanwhile while configuration writes are still taken.
module sound_file_bank_mapper_with_irq_timer_top #(
  parameter int unsigned WORK_RAM_BYTES = sfbm_pkg::WORK_RAM_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sfbm_pkg::PADDR_W-1:0]        paddr,
  input  logic [sfbm_pkg::PDATA_W-1:0]        pwdata,
  output logic [sfbm_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready,
  // Input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [sfbm_pkg::CMD_W-1:0]          cmd,
  input  logic [sfbm_pkg::ADDR_W-1:0]         address,
  input  logic [sfbm_pkg::DATA_W-1:0]         write_data,
  input  logic [sfbm_pkg::DATA_W-1:0]         open_bus_data,
  // Output channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sfbm_pkg::DATA_W-1:0]         read_data,
  output logic                                rom_fetch,
  output logic [sfbm_pkg::ROM_ADDR_W-1:0]     rom_address,
  output logic                                irq_pending
);

  localparam int unsigned RAM_AW = $clog2(WORK_RAM_BYTES);
  localparam int unsigned WIN_W  = sfbm_pkg::RAM_WINDOW_W + sfbm_pkg::RAM_FOLD_STEPS;

  // Configuration registers
  logic bank_switch_enable;
  logic irq_extension_enable;

  // Mapper state
  logic [sfbm_pkg::DATA_W-1:0] bank_select [sfbm_pkg::BANK_COUNT];
  logic [15:0]                 irq_reload;
  logic [15:0]                 irq_countdown;
  logic                        irq_enable;
  logic                        irq_pend;
  logic [15:0]                 vec_value;

  // Next values of the mapper state
  logic [15:0] irq_reload_next;
  logic [15:0] irq_countdown_next;
  logic        irq_enable_next;
  logic        irq_pend_next;
  logic [15:0] vec_value_next;
  logic        bank_wr;

  // Work RAM and its clearing pass
  logic [sfbm_pkg::DATA_W-1:0] work_ram [WORK_RAM_BYTES];
  logic [sfbm_pkg::DATA_W-1:0] ram_q;
  logic [RAM_AW-1:0]           ram_idx;
  logic                        ram_wr;
  logic                        ram_rd;
  logic                        clr_busy;
  logic [RAM_AW-1:0]           clr_idx;

  // Read stage and result queue
  logic                                 accept;
  sfbm_pkg::result_t                    res;
  logic                                 p1_valid;
  logic                                 p1_ram;
  sfbm_pkg::result_t                    p1_res;
  sfbm_pkg::result_t                    push_res;
  sfbm_pkg::result_t                    out_q [sfbm_pkg::OUT_DEPTH];
  logic [sfbm_pkg::OUT_PTR_W-1:0]       wr_ptr;
  logic [sfbm_pkg::OUT_PTR_W-1:0]       rd_ptr;
  logic [sfbm_pkg::OUT_COUNT_W-1:0]     count;
  logic [sfbm_pkg::OUT_COUNT_W-1:0]     in_flight;
  logic                                 pop;

  // Configuration port: writes decode on the register bit of paddr alone.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_switch_enable   <= 1'b0;
      irq_extension_enable <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        sfbm_pkg::REG_BANK_SWITCH: bank_switch_enable   <= pwdata[0];
        sfbm_pkg::REG_IRQ_EXT:     irq_extension_enable <= pwdata[0];
        default:                   ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr[2])
      sfbm_pkg::REG_BANK_SWITCH: prdata[0] = bank_switch_enable;
      sfbm_pkg::REG_IRQ_EXT:     prdata[0] = irq_extension_enable;
      default:                   prdata = '0;
    endcase
  end

  // Handshake: room is kept for every beat that is already on its way to the queue.
  assign in_flight = count + sfbm_pkg::OUT_COUNT_W'(p1_valid);
  assign in_ready  = !clr_busy && (in_flight < sfbm_pkg::OUT_COUNT_W'(sfbm_pkg::OUT_DEPTH));
  assign accept    = in_valid && in_ready;

  // Work RAM index: the 8 KB window folded onto a RAM no larger than it by restoring subtraction,
  // one quotient bit per step, so only three compare-and-subtract stages are chained.
  always_comb begin
    logic [WIN_W-1:0] off;
    off = WIN_W'(address[sfbm_pkg::RAM_WINDOW_W-1:0]);
    for (int k = sfbm_pkg::RAM_FOLD_STEPS - 1; k >= 0; k--) begin
      if (off >= WIN_W'(WORK_RAM_BYTES << k)) begin
        off = off - WIN_W'(WORK_RAM_BYTES << k);
      end
    end
    ram_idx = off[RAM_AW-1:0];
  end

  // Decode of one beat: its result and the next mapper state.
  always_comb begin
    res                = '0;
    irq_reload_next    = irq_reload;
    irq_countdown_next = irq_countdown;
    irq_enable_next    = irq_enable;
    irq_pend_next      = irq_pend;
    vec_value_next     = vec_value;
    bank_wr            = 1'b0;
    ram_wr             = 1'b0;
    ram_rd             = 1'b0;
    case (cmd)
      sfbm_pkg::CMD_READ: begin
        if (address < sfbm_pkg::ADDR_RAM) begin
          if (irq_extension_enable && address == sfbm_pkg::ADDR_RELOAD_LO) begin
            res.read_data = irq_reload[7:0];
          end else if (irq_extension_enable && address == sfbm_pkg::ADDR_RELOAD_HI) begin
            res.read_data = irq_reload[15:8];
          end else if (irq_extension_enable && address == sfbm_pkg::ADDR_STATUS) begin
            // The status read returns the pending flag and then clears it.
            res.read_data = {irq_pend, 6'b0, irq_enable};
            irq_pend_next = 1'b0;
          end else begin
            res.read_data = open_bus_data;
          end
        end else if (address < sfbm_pkg::ADDR_PRG) begin
          ram_rd = 1'b1;
        end else if (irq_extension_enable && address >= sfbm_pkg::ADDR_VEC_LO) begin
          res.read_data = address[0] ? vec_value[15:8] : vec_value[7:0];
        end else begin
          res.rom_fetch = 1'b1;
          if (bank_switch_enable) begin
            res.rom_address = {bank_select[address[sfbm_pkg::PRG_OFF_W-1:sfbm_pkg::BANK_OFF_W]],
                               address[sfbm_pkg::BANK_OFF_W-1:0]};
          end else begin
            res.rom_address = sfbm_pkg::ROM_ADDR_W'(address[sfbm_pkg::PRG_OFF_W-1:0]);
          end
        end
      end
      sfbm_pkg::CMD_WRITE: begin
        if (address < sfbm_pkg::ADDR_RAM) begin
          if (irq_extension_enable && address == sfbm_pkg::ADDR_RELOAD_LO) begin
            irq_reload_next[7:0] = write_data;
          end else if (irq_extension_enable && address == sfbm_pkg::ADDR_RELOAD_HI) begin
            irq_reload_next[15:8] = write_data;
          end else if (irq_extension_enable && address == sfbm_pkg::ADDR_STATUS) begin
            irq_enable_next = irq_enable | write_data[0];
          end
          bank_wr = (address >= sfbm_pkg::ADDR_BANK_BASE);
        end else if (address < sfbm_pkg::ADDR_PRG) begin
          ram_wr = 1'b1;
        end else if (irq_extension_enable && address == sfbm_pkg::ADDR_VEC_LO) begin
          vec_value_next[7:0] = write_data;
        end else if (irq_extension_enable && address > sfbm_pkg::ADDR_VEC_LO) begin
          vec_value_next[15:8] = write_data;
        end
      end
      sfbm_pkg::CMD_TICK: begin
        // Enabled timer: reload and raise the request at zero, else count down.
        if (irq_extension_enable && irq_enable) begin
          if (irq_countdown == 16'd0) begin
            irq_pend_next      = 1'b1;
            irq_countdown_next = irq_reload;
          end else begin
            irq_countdown_next = irq_countdown - 16'd1;
          end
        end
      end
      default: ;
    endcase
    res.irq_pending = irq_pend_next;
  end

  // Mapper state registers, updated at the accepting edge.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < sfbm_pkg::BANK_COUNT; i++) begin
        bank_select[i] <= '0;
      end
      irq_reload    <= '0;
      irq_countdown <= '0;
      irq_enable    <= 1'b0;
      irq_pend      <= 1'b0;
      vec_value     <= '0;
    end else if (accept) begin
      if (bank_wr) begin
        bank_select[address[sfbm_pkg::BANK_IDX_W-1:0]] <= write_data;
      end
      irq_reload    <= irq_reload_next;
      irq_countdown <= irq_countdown_next;
      irq_enable    <= irq_enable_next;
      irq_pend      <= irq_pend_next;
      vec_value     <= vec_value_next;
    end
  end

  // Clearing pass over the work RAM after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_idx  <= '0;
    end else if (clr_busy) begin
      clr_idx <= clr_idx + RAM_AW'(1);
      if (clr_idx == RAM_AW'(WORK_RAM_BYTES - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // Work RAM: one port, written by the clearing pass or a write beat, read by a read beat.
  always_ff @(posedge clk) begin
    if (clr_busy) begin
      work_ram[clr_idx] <= '0;
    end else if (accept && ram_wr) begin
      work_ram[ram_idx] <= write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && ram_rd) begin
      ram_q <= work_ram[ram_idx];
    end
  end

  // Read stage: the beat is held here while the synchronous RAM read completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_res <= res;
      p1_ram <= ram_rd;
    end
  end

  always_comb begin
    push_res = p1_res;
    if (p1_ram) begin
      push_res.read_data = ram_q;
    end
  end

  // Result queue towards the output channel.
  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (p1_valid) begin
        wr_ptr <= wr_ptr + sfbm_pkg::OUT_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + sfbm_pkg::OUT_PTR_W'(1);
      end
      count <= count + sfbm_pkg::OUT_COUNT_W'(p1_valid) - sfbm_pkg::OUT_COUNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (p1_valid) begin
      out_q[wr_ptr] <= push_res;
    end
  end

  assign read_data   = out_q[rd_ptr].read_data;
  assign rom_fetch   = out_q[rd_ptr].rom_fetch;
  assign rom_address = out_q[rd_ptr].rom_address;
  assign irq_pending = out_q[rd_ptr].irq_pending;

endmodule
